FILE: hw/rtl/plas_pkg.sv
// Shared types, widths and the arctangent table of the launch angle solver.
package plas_pkg;

    localparam int IN_W   = 24;
    localparam int ANG_W  = 23;
    localparam int E_W    = 101;
    localparam int ROOT_W = 50;
    localparam int FA_W   = 49;
    localparam int XA_W   = 37;
    localparam int CX_W   = 53;
    localparam int Z_W    = 26;
    localparam int TAB_W  = 22;

    localparam logic [ANG_W-1:0] ANGLE_90 = 23'd5898240;

    typedef struct packed {
        logic            reject;
        logic            d_neg;
        logic [XA_W-1:0] xa;
        logic [FA_W-1:0] fa;
    } meta_t;

    function automatic logic [TAB_W-1:0] atan_deg(input logic [4:0] idx);
        logic [TAB_W-1:0] r;
        case (idx)
            5'd0:    r = 22'd2949120;
            5'd1:    r = 22'd1740967;
            5'd2:    r = 22'd919879;
            5'd3:    r = 22'd466945;
            5'd4:    r = 22'd234379;
            5'd5:    r = 22'd117304;
            5'd6:    r = 22'd58666;
            5'd7:    r = 22'd29335;
            5'd8:    r = 22'd14668;
            5'd9:    r = 22'd7334;
            5'd10:   r = 22'd3667;
            5'd11:   r = 22'd1833;
            5'd12:   r = 22'd917;
            5'd13:   r = 22'd458;
            5'd14:   r = 22'd229;
            5'd15:   r = 22'd115;
            5'd16:   r = 22'd57;
            5'd17:   r = 22'd29;
            5'd18:   r = 22'd14;
            5'd19:   r = 22'd7;
            5'd20:   r = 22'd4;
            5'd21:   r = 22'd2;
            5'd22:   r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/plas_disc.sv
// Five-stage discriminant pipeline with request validity checks.
module plas_disc
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [plas_pkg::IN_W-1:0] launch_height,
    input  logic signed [plas_pkg::IN_W-1:0] launch_speed,
    input  logic signed [plas_pkg::IN_W-1:0] target_distance,
    input  logic signed [plas_pkg::IN_W-1:0] target_height,
    input  logic signed [plas_pkg::IN_W-1:0] obstacle_offset,
    input  logic signed [plas_pkg::IN_W-1:0] obstacle_width,
    output logic                          out_valid,
    output plas_pkg::meta_t               out_meta,
    output logic [plas_pkg::E_W-2:0]      out_e
);

    logic [4:0] vld_reg;

    // stage 1
    logic            rej1_next;
    logic [23:0]     dabs1_next;
    logic            rej1_reg, dneg1_reg;
    logic [45:0]     a1_reg;
    logic [47:0]     d2_1_reg;
    logic [23:0]     dabs1_reg;
    logic signed [24:0] dt1_reg;

    // stage 2
    logic [24:0]     adt2_next;
    logic            rej2_reg, dneg2_reg, dtn2_reg;
    logic [48:0]     fa2_reg;
    logic [59:0]     d2k2_reg;
    logic [47:0]     pah2_reg, pal2_reg;
    logic [36:0]     xa2_reg;

    // stage 3
    logic            rej3_reg, dneg3_reg, dtn3_reg;
    logic [48:0]     fa3_reg;
    logic [59:0]     d2k3_reg;
    logic [47:0]     hh3_reg;
    logic [48:0]     hl3_reg;
    logic [49:0]     ll3_reg;
    logic [70:0]     p3_reg;
    logic [36:0]     xa3_reg;

    // stage 4
    logic            rej4_reg, dneg4_reg, dtn4_reg;
    logic [48:0]     fa4_reg;
    logic [59:0]     d2k4_reg;
    logic [97:0]     sq4_reg;
    logic [78:0]     tm4_reg;
    logic [36:0]     xa4_reg;

    // stage 5
    logic [100:0]    e5_next;
    plas_pkg::meta_t meta5_reg;
    logic [99:0]     e5_reg;

    always_comb
    begin
        rej1_next = launch_speed <= 0 || launch_height <= 0 || obstacle_width <= 0
                    || target_distance == 0
                    || (obstacle_offset < 0 && target_distance > 0)
                    || (obstacle_offset > 0 && target_distance < 0);
        dabs1_next = target_distance[23] ? 24'(-target_distance) : 24'(target_distance);
        adt2_next = dt1_reg[24] ? 25'(-dt1_reg) : 25'(dt1_reg);
        e5_next = 101'(sq4_reg) - (101'(d2k4_reg) << 16);
        if (dtn4_reg)
        begin
            e5_next = e5_next + (101'(tm4_reg) << 9);
        end
        else
        begin
            e5_next = e5_next - (101'(tm4_reg) << 9);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rej1_reg  <= rej1_next;
        dneg1_reg <= target_distance[23];
        a1_reg    <= 46'(launch_speed[22:0]) * 46'(launch_speed[22:0]);
        d2_1_reg  <= 48'(dabs1_next) * 48'(dabs1_next);
        dabs1_reg <= dabs1_next;
        dt1_reg   <= 25'(target_height) - 25'(launch_height);

        rej2_reg  <= rej1_reg;
        dneg2_reg <= dneg1_reg;
        dtn2_reg  <= dt1_reg[24];
        fa2_reg   <= (49'(a1_reg) << 2) + 49'(a1_reg);
        d2k2_reg  <= 60'(d2_1_reg) * 60'd2401;
        pah2_reg  <= 48'(a1_reg[45:23]) * 48'(adt2_next);
        pal2_reg  <= 48'(a1_reg[22:0]) * 48'(adt2_next);
        xa2_reg   <= 37'(dabs1_reg) * 37'd12544;

        rej3_reg  <= rej2_reg;
        dneg3_reg <= dneg2_reg;
        dtn3_reg  <= dtn2_reg;
        fa3_reg   <= fa2_reg;
        d2k3_reg  <= d2k2_reg;
        hh3_reg   <= 48'(fa2_reg[48:25]) * 48'(fa2_reg[48:25]);
        hl3_reg   <= 49'(fa2_reg[48:25]) * 49'(fa2_reg[24:0]);
        ll3_reg   <= 50'(fa2_reg[24:0]) * 50'(fa2_reg[24:0]);
        p3_reg    <= (71'(pah2_reg) << 23) + 71'(pal2_reg);
        xa3_reg   <= xa2_reg;

        rej4_reg  <= rej3_reg;
        dneg4_reg <= dneg3_reg;
        dtn4_reg  <= dtn3_reg;
        fa4_reg   <= fa3_reg;
        d2k4_reg  <= d2k3_reg;
        sq4_reg   <= (98'(hh3_reg) << 50) + (98'(hl3_reg) << 26) + 98'(ll3_reg);
        tm4_reg   <= 79'(p3_reg) * 79'd245;
        xa4_reg   <= xa3_reg;

        meta5_reg.reject <= rej4_reg | e5_next[100];
        meta5_reg.d_neg  <= dneg4_reg;
        meta5_reg.xa     <= xa4_reg;
        meta5_reg.fa     <= fa4_reg;
        e5_reg           <= e5_next[99:0];
    end

    assign out_valid = vld_reg[4];
    assign out_meta  = meta5_reg;
    assign out_e     = e5_reg;

endmodule

FILE: hw/rtl/plas_sqrt.sv
// Pipelined restoring square root, one root bit per stage.
module plas_sqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  plas_pkg::meta_t              in_meta,
    input  logic [plas_pkg::E_W-2:0]     in_e,
    output logic                         out_valid,
    output plas_pkg::meta_t              out_meta,
    output logic [plas_pkg::ROOT_W-1:0]  out_root
);

    localparam int RW = plas_pkg::ROOT_W;
    localparam int EW = plas_pkg::E_W;

    logic            vld_reg  [0:RW-1];
    plas_pkg::meta_t meta_reg [0:RW-1];
    logic [RW-1:0]   root_reg [0:RW-1];
    logic [EW-1:0]   rem_reg  [0:RW-2];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        localparam int B = RW - 1 - k;
        logic            vld_in;
        plas_pkg::meta_t meta_in;
        logic [RW-1:0]   root_in;
        logic [EW-1:0]   rem_in;
        logic [EW-1:0]   trial;
        logic            fits;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign meta_in = in_meta;
            assign root_in = '0;
            assign rem_in  = EW'(in_e);
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign meta_in = meta_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rem_in  = rem_reg[k-1];
        end

        assign trial = (EW'(root_in) << (B + 1)) | (EW'(1) << (2 * B));
        assign fits  = rem_in >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            meta_reg[k] <= meta_in;
            root_reg[k] <= fits ? (root_in | (RW'(1) << B)) : root_in;
        end

        if (k < RW - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= fits ? (rem_in - trial) : rem_in;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign out_meta  = meta_reg[RW-1];
    assign out_root  = root_reg[RW-1];

endmodule

FILE: hw/rtl/plas_cordic.sv
// Pipelined vectoring CORDIC lane giving the angle in 1/65536 degree.
module plas_cordic
#(
    parameter int STAGES = 24
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ok,
    input  logic [plas_pkg::XA_W-1:0]           in_x,
    input  logic [plas_pkg::ROOT_W-1:0]         in_y,
    output logic                                out_valid,
    output logic                                out_ok,
    output logic signed [plas_pkg::Z_W-1:0]     out_z
);

    localparam int CW = plas_pkg::CX_W;
    localparam int ZW = plas_pkg::Z_W;

    logic                 vld_reg [0:STAGES-1];
    logic                 ok_reg  [0:STAGES-1];
    logic signed [CW-1:0] x_reg   [0:STAGES-1];
    logic signed [CW-1:0] y_reg   [0:STAGES-1];
    logic signed [ZW-1:0] z_reg   [0:STAGES-1];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic                 vld_in, ok_in;
        logic signed [CW-1:0] x_in, y_in, dx, dy;
        logic signed [ZW-1:0] z_in, rot;

        if (i == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign ok_in  = in_ok;
            assign x_in   = CW'(in_x);
            assign y_in   = CW'(in_y);
            assign z_in   = '0;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[i-1];
            assign ok_in  = ok_reg[i-1];
            assign x_in   = x_reg[i-1];
            assign y_in   = y_reg[i-1];
            assign z_in   = z_reg[i-1];
        end

        assign dx  = y_in >>> i;
        assign dy  = x_in >>> i;
        assign rot = signed'(ZW'(plas_pkg::atan_deg(5'(i))));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            ok_reg[i] <= ok_in;
            if (!y_in[CW-1])
            begin
                x_reg[i] <= x_in + dx;
                y_reg[i] <= y_in - dy;
                z_reg[i] <= z_in + rot;
            end
            else
            begin
                x_reg[i] <= x_in - dx;
                y_reg[i] <= y_in + dy;
                z_reg[i] <= z_in - rot;
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_ok    = ok_reg[STAGES-1];
    assign out_z     = z_reg[STAGES-1];

endmodule

FILE: hw/rtl/projectile_launch_angle_solver.sv
// Top level of the projectile launch angle solver pipeline.
//
//  channel  | handshake       | beat fields
//  ---------+-----------------+-----------------------------------------------
//  request  | start / busy    | launch_height launch_speed target_distance
//           |                 | target_height obstacle_offset obstacle_width
//  result   | done            | hit launch_angle
//
//  One request per cycle; busy is always low.
//  The pipeline has 5 discriminant stages, 50 square root stages (one root
//  bit each), 1 root setup stage, CORDIC_STAGES arctangent stages and 1
//  select stage.
//  Reset clears only the valid bits and hit. done pulses for exactly one
//  cycle per request, in request order.
module projectile_launch_angle_solver
#(
    parameter int CORDIC_STAGES = 24
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [plas_pkg::IN_W-1:0]    launch_height,
    input  logic signed [plas_pkg::IN_W-1:0]    launch_speed,
    input  logic signed [plas_pkg::IN_W-1:0]    target_distance,
    input  logic signed [plas_pkg::IN_W-1:0]    target_height,
    input  logic signed [plas_pkg::IN_W-1:0]    obstacle_offset,
    input  logic signed [plas_pkg::IN_W-1:0]    obstacle_width,
    output logic                                done,
    output logic                                hit,
    output logic [plas_pkg::ANG_W-1:0]          launch_angle
);

    localparam int RW = plas_pkg::ROOT_W;
    localparam int ZW = plas_pkg::Z_W;

    logic                         dv, sv;
    plas_pkg::meta_t              dmeta, smeta;
    logic [plas_pkg::E_W-2:0]     de;
    logic [RW-1:0]                sroot;

    logic [RW-1:0]                yh_next;
    logic [RW:0]                  yl_next;
    logic [RW-1:0]                yla_next;
    logic                         okh_next, okl_next;

    logic                         pvld_reg, okh_reg, okl_reg;
    logic [plas_pkg::XA_W-1:0]    px_reg;
    logic [RW-1:0]                pyh_reg, pyl_reg;

    logic                         vh, vl, okh, okl;
    logic signed [ZW-1:0]         zh, zl;
    logic                         hith, hitl;

    logic                         done_reg, hit_reg;
    logic [plas_pkg::ANG_W-1:0]   angle_reg;

    plas_disc u_disc
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (start),
        .launch_height   (launch_height),
        .launch_speed    (launch_speed),
        .target_distance (target_distance),
        .target_height   (target_height),
        .obstacle_offset (obstacle_offset),
        .obstacle_width  (obstacle_width),
        .out_valid       (dv),
        .out_meta        (dmeta),
        .out_e           (de)
    );

    plas_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv),
        .in_meta   (dmeta),
        .in_e      (de),
        .out_valid (sv),
        .out_meta  (smeta),
        .out_root  (sroot)
    );

    always_comb
    begin
        yh_next  = RW'(smeta.fa) + sroot;
        yl_next  = (RW+1)'(smeta.fa) - (RW+1)'(sroot);
        yla_next = yl_next[RW] ? RW'(-yl_next) : RW'(yl_next);
        okh_next = !smeta.reject && !smeta.d_neg;
        okl_next = !smeta.reject && yl_next != '0 && (yl_next[RW] == smeta.d_neg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg <= 1'b0;
        end
        else
        begin
            pvld_reg <= sv;
        end
    end

    always_ff @(posedge clk)
    begin
        okh_reg <= okh_next;
        okl_reg <= okl_next;
        px_reg  <= smeta.xa;
        pyh_reg <= yh_next;
        pyl_reg <= yla_next;
    end

    plas_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_high
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pvld_reg),
        .in_ok     (okh_reg),
        .in_x      (px_reg),
        .in_y      (pyh_reg),
        .out_valid (vh),
        .out_ok    (okh),
        .out_z     (zh)
    );

    plas_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_low
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pvld_reg),
        .in_ok     (okl_reg),
        .in_x      (px_reg),
        .in_y      (pyl_reg),
        .out_valid (vl),
        .out_ok    (okl),
        .out_z     (zl)
    );

    assign hith = okh && zh > 0 && zh < signed'(ZW'(plas_pkg::ANGLE_90));
    assign hitl = okl && zl > 0 && zl < signed'(ZW'(plas_pkg::ANGLE_90));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= vh & vl;
            hit_reg  <= vh & vl & (hith | hitl);
        end
    end

    always_ff @(posedge clk)
    begin
        if (hith)
        begin
            angle_reg <= plas_pkg::ANG_W'(zh);
        end
        else if (hitl)
        begin
            angle_reg <= plas_pkg::ANG_W'(zl);
        end
        else
        begin
            angle_reg <= '0;
        end
    end

    assign busy         = 1'b0;
    assign done         = done_reg;
    assign hit          = hit_reg;
    assign launch_angle = angle_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> launch_angle == '0)
        else $error("miss with nonzero angle");

    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> launch_angle != '0 && launch_angle < plas_pkg::ANGLE_90)
        else $error("hit angle out of range");

    a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> done)
        else $error("hit without done");

    a_lanes_step: assert property (@(posedge clk) disable iff (!rst_n)
        vh == vl)
        else $error("cordic lanes out of step");

endmodule

FILE: dv/projectile_launch_angle_solver_test.sv
// Self-checking testbench of the projectile launch angle solver.
module projectile_launch_angle_solver_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES     = 24;
    localparam int NUM_ITEMS  = 950;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN      = 120;

    typedef logic signed [plas_pkg::IN_W-1:0] fld_t;

    typedef struct packed {
        logic                       hit;
        logic [plas_pkg::ANG_W-1:0] angle;
    } shot_t;

    class angle_board;
        shot_t pending[$];
        int    mismatches;
        int    hits;
        int    requests;
        longint step_deg[32];

        function new();
            step_deg = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                         29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
            mismatches = 0;
            hits = 0;
            requests = 0;
        endfunction

        function longint vector_angle(longint x, longint y);
            longint z;
            longint dx;
            longint dy;
            z = 0;
            for (int i = 0; i < STAGES && i < 32; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + step_deg[i];
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - step_deg[i];
                end
            end
            return z;
        endfunction

        function bit root_angle(longint x, longint y, output longint ang);
            ang = 0;
            if (x == 0 || y == 0 || ((x < 0) != (y < 0)))
                return 0;
            ang = vector_angle(x < 0 ? -x : x, y < 0 ? -y : y);
            return (ang > 0 && ang < longint'(plas_pkg::ANGLE_90));
        endfunction

        function shot_t solve_angle(fld_t h, fld_t v, fld_t d, fld_t t, fld_t b, fld_t w);
            shot_t r;
            logic signed [127:0] aa;
            logic signed [127:0] dd;
            logic signed [127:0] dt;
            logic signed [127:0] disc;
            logic [127:0] c;
            longint s;
            longint ang;
            longint x;
            bit ok;
            r = '0;
            if (v <= 0 || h <= 0 || w <= 0 || d == 0)
                return r;
            if ((b < 0 && d > 0) || (b > 0 && d < 0))
                return r;
            aa = 128'(longint'(v) * longint'(v));
            dd = d;
            dt = longint'(t) - longint'(h);
            disc = 25 * aa * aa - 157351936 * dd * dd - 125440 * dt * aa;
            if (disc < 0)
                return r;
            s = 0;
            for (int k = 49; k >= 0; k--)
            begin
                c = 128'(s | (64'd1 << k));
                if (c * c <= 128'(disc))
                    s = longint'(c);
            end
            x = 12544 * longint'(d);
            ok = root_angle(x, longint'(5 * aa) + s, ang);
            if (!ok)
                ok = root_angle(x, longint'(5 * aa) - s, ang);
            if (ok)
            begin
                r.hit = 1'b1;
                r.angle = ang[plas_pkg::ANG_W-1:0];
            end
            return r;
        endfunction

        function void note_request(fld_t h, fld_t v, fld_t d, fld_t t, fld_t b, fld_t w);
            shot_t r;
            r = solve_angle(h, v, d, t, b, w);
            requests++;
            if (r.hit)
                hits++;
            pending.push_back(r);
        endfunction

        function void check_result(logic hit_q, logic [plas_pkg::ANG_W-1:0] ang_q);
            shot_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing pending: hit=%0d angle=%0d", hit_q, ang_q);
                return;
            end
            e = pending.pop_front();
            if (e.hit !== hit_q || e.angle !== ang_q)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected hit=%0d angle=%0d, got hit=%0d angle=%0d",
                             e.hit, e.angle, hit_q, ang_q);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    fld_t launch_height = '0;
    fld_t launch_speed = '0;
    fld_t target_distance = '0;
    fld_t target_height = '0;
    fld_t obstacle_offset = '0;
    fld_t obstacle_width = '0;
    logic done;
    logic hit;
    logic [plas_pkg::ANG_W-1:0] launch_angle;

    angle_board board = new();
    int idle_cycles = 0;

    always #2 clk = ~clk;

    projectile_launch_angle_solver #(.CORDIC_STAGES(STAGES)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .launch_height(launch_height),
        .launch_speed(launch_speed),
        .target_distance(target_distance),
        .target_height(target_height),
        .obstacle_offset(obstacle_offset),
        .obstacle_width(obstacle_width),
        .done(done),
        .hit(hit),
        .launch_angle(launch_angle)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_request(launch_height, launch_speed, target_distance,
                                   target_height, obstacle_offset, obstacle_width);
            if (done)
                board.check_result(hit, launch_angle);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("projectile_launch_angle_solver_test: done, errors");
                $finish;
            end
        end
    end

    task automatic send_request(fld_t h, fld_t v, fld_t d, fld_t t, fld_t b, fld_t w);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start = 1'b1;
        launch_height = h;
        launch_speed = v;
        target_distance = d;
        target_height = t;
        obstacle_offset = b;
        obstacle_width = w;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic fld_t rand_field();
        int k;
        k = $urandom_range(1, 24);
        return fld_t'($urandom & ((32'd1 << k) - 1));
    endfunction

    function automatic fld_t rand_mag(int lo_bits, int hi_bits);
        int k;
        k = $urandom_range(lo_bits, hi_bits);
        return fld_t'(($urandom & ((32'd1 << k) - 1)) | 32'd1) & 24'h7FFFFF;
    endfunction

    task automatic send_shaped();
        fld_t v;
        fld_t d;
        fld_t h;
        fld_t t;
        fld_t b;
        longint reach;
        v = rand_mag(4, 23);
        if (v == 0)
            v = 1;
        reach = (longint'(v) * longint'(v)) / 2509;
        if (reach < 1)
            reach = 1;
        if (reach > 8388607)
            reach = 8388607;
        d = fld_t'(longint'($urandom) % reach + 1);
        if ($urandom_range(0, 3) == 0)
            d = fld_t'(($urandom & 32'hFF) + 1);
        h = rand_mag(1, 20);
        if (h == 0)
            h = 1;
        t = $urandom_range(0, 1) ? rand_mag(1, 20) : -rand_mag(1, 20);
        b = rand_mag(0, 23);
        if ($urandom_range(0, 1))
        begin
            d = -d;
            b = -b;
        end
        send_request(h, v, d, t, b, rand_mag(1, 23));
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_request(24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000);
        send_request('0, '0, '0, '0, '0, '0);
        send_request(256, 0, 2560, 0, 1, 256);
        send_request(0, 5120, 2560, 0, 1, 256);
        send_request(256, 5120, 2560, 0, 1, 0);
        send_request(256, 5120, 2560, 0, -1, 256);
        send_request(256, 5120, -2560, 0, 1, 256);
        send_request(256, 5120, 0, 0, 1, 256);
        send_request(256, 256, 25600, 0, 1, 256);
        send_request(256, 5120, 2560, 0, 0, 256);
        send_request(256, 5120, -2560, 0, -256, 256);
        send_request(2560, 5120, 2560, 0, 1, 256);
        send_request(256, 5120, 2560, 25600, 1, 256);
        send_request(256, 24'sh7FFFFF, 1, 0, 1, 256);
        send_request(256, 800, 256, 0, 1, 256);
        send_request(256, 5120, 10240, 256, 1, 24'sh7FFFFF);
        send_request(1, 1, 1, 1, 1, 1);

        for (int n = 18; n < NUM_ITEMS; n++)
        begin
            if (n == NUM_ITEMS / 2)
            begin
                @(negedge clk);
                start = 1'b0;
                while (board.pending.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 3) == 0)
                send_request(rand_field(), rand_field(), rand_field(), rand_field(),
                             rand_field(), rand_field());
            else
                send_shaped();
        end
        @(negedge clk);
        start = 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d requests, %0d with a launch angle, %0d mismatches",
                 board.requests, board.hits, board.mismatches);
        if (board.mismatches == 0)
            $display("projectile_launch_angle_solver_test: done, clean");
        else
            $display("projectile_launch_angle_solver_test: done, errors");
        $finish;
    end
endmodule
